// ----- rtl/core/nps_pkg.sv -----
package nps_pkg;

  // default table depth
  localparam int unsigned MaxEntriesDef = 1024;

  // payload widths
  localparam int unsigned KeyW   = 64;
  localparam int unsigned OwnerW = 8;
  localparam int unsigned PortW  = 16;
  localparam int unsigned CountW = 11;

  // configuration port
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 16;
  localparam logic [CfgIdxW-1:0] CfgFirstPort = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgPortCount = 1'd1;

  localparam logic [PortW-1:0]  FirstPortRst = 16'd1024;
  localparam logic [CountW-1:0] PortCountRst = 11'd1024;

  typedef enum logic [1:0] {
    OP_REGISTER   = 2'd0,
    OP_UNREGISTER = 2'd1,
    OP_LOOKUP     = 2'd2,
    OP_RELEASE    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_EXISTS  = 2'd1,
    ST_NO_FREE = 2'd2,
    ST_UNKNOWN = 2'd3
  } status_e;

  // one slot of the table memory
  typedef struct packed {
    logic              vld;
    logic [OwnerW-1:0] owner;
    logic [KeyW-1:0]   key;
  } slot_t;

endpackage

// ----- rtl/core/nps_req_if.sv -----
interface nps_req_if import nps_pkg::*; ();
  logic              valid;
  logic              ready;
  op_e               op;
  logic [KeyW-1:0]   name_key;
  logic [OwnerW-1:0] owner_id;

  modport source (output valid, op, name_key, owner_id, input ready);
  modport sink (input valid, op, name_key, owner_id, output ready);
endinterface

// ----- rtl/core/nps_rsp_if.sv -----
interface nps_rsp_if import nps_pkg::*; ();
  logic             valid;
  logic             ready;
  status_e          status;
  logic [PortW-1:0] port_number;

  modport source (output valid, status, port_number, input ready);
  modport sink (input valid, status, port_number, output ready);
endinterface

// ----- rtl/core/named_port_slot_allocator.sv -----
// Register and lookup raise rsp.valid once the scan of the active slots ends, sooner
// when the key is found.
// One request at a time: the slot memory is scanned one entry per cycle through its single
// read port, so a request occupies the block through the scan and the finishing step, plus
// any wait for rsp.ready to free the answer register.
// Reset is asynchronous, active low; after it a clearing pass over all MAX_ENTRIES slots
// marks every slot free, and requests are held off until it ends (config writes are taken).
module named_port_slot_allocator import nps_pkg::*; #(
  parameter int unsigned MAX_ENTRIES = MaxEntriesDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  nps_req_if.sink             req,
  nps_rsp_if.source           rsp
);

  localparam int unsigned IdxW = $clog2(MAX_ENTRIES);
  localparam int unsigned CntW = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned CmpW = (CntW > CountW) ? CntW : CountW;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_e;

  state_e              state_q, state_d;
  logic [PortW-1:0]    first_port_q;
  logic [CountW-1:0]   port_count_q;
  logic [IdxW-1:0]     clr_q, clr_d;
  logic [CntW-1:0]     n_q, n_d;
  logic [CntW-1:0]     issue_q, issue_d;
  logic                chk_vld_q, chk_vld_d;
  logic [IdxW-1:0]     chk_idx_q, chk_idx_d;
  op_e                 op_q, op_d;
  logic [KeyW-1:0]     key_q, key_d;
  logic [OwnerW-1:0]   owner_q, owner_d;
  logic                hit_q, hit_d;
  logic [IdxW-1:0]     hit_idx_q, hit_idx_d;
  logic                free_q, free_d;
  logic [IdxW-1:0]     free_idx_q, free_idx_d;
  logic                out_vld_q, out_vld_d;
  status_e             out_st_q, out_st_d;
  logic [PortW-1:0]    out_port_q, out_port_d;

  slot_t               mem [MAX_ENTRIES];
  slot_t               rd_data_q;
  logic                rd_en;
  logic [IdxW-1:0]     rd_addr;
  logic                wr_en;
  logic [IdxW-1:0]     wr_addr;
  slot_t               wr_data;

  logic [CntW-1:0]     act_n;
  logic                req_acc;
  logic                out_free;
  logic                key_hit;
  logic                own_hit;
  logic                last_chk;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_port_q <= FirstPortRst;
      port_count_q <= PortCountRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgFirstPort: first_port_q <= cfg_wdata_i[PortW-1:0];
        CfgPortCount: port_count_q <= cfg_wdata_i[CountW-1:0];
        default: ;
      endcase
    end
  end

  // active slot count, saturated at table depth
  always_comb begin
    if (CmpW'(port_count_q) > CmpW'(MAX_ENTRIES)) begin
      act_n = CntW'(MAX_ENTRIES);
    end else begin
      act_n = CntW'(port_count_q);
    end
  end

  // slot memory, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  assign req.ready   = (state_q == S_IDLE);
  assign req_acc     = req.valid && req.ready;
  assign out_free    = !out_vld_q || rsp.ready;
  assign key_hit     = rd_data_q.vld && (rd_data_q.key == key_q);
  assign own_hit     = rd_data_q.vld && (rd_data_q.owner == owner_q);
  assign last_chk    = (CntW'(chk_idx_q) + CntW'(1)) == n_q;

  assign rsp.valid       = out_vld_q;
  assign rsp.status      = out_st_q;
  assign rsp.port_number = out_port_q;

  // next state and memory access
  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    n_d        = n_q;
    issue_d    = issue_q;
    chk_vld_d  = 1'b0;
    chk_idx_d  = chk_idx_q;
    op_d       = op_q;
    key_d      = key_q;
    owner_d    = owner_q;
    hit_d      = hit_q;
    hit_idx_d  = hit_idx_q;
    free_d     = free_q;
    free_idx_d = free_idx_q;
    out_vld_d  = out_vld_q && !rsp.ready;
    out_st_d   = out_st_q;
    out_port_d = out_port_q;
    rd_en      = 1'b0;
    rd_addr    = '0;
    wr_en      = 1'b0;
    wr_addr    = chk_idx_q;
    wr_data    = '0;

    case (state_q)
      // mark every slot free after reset
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_q;
        clr_d   = clr_q + IdxW'(1);
        if (clr_q == IdxW'(MAX_ENTRIES - 1)) begin
          state_d = S_IDLE;
        end
      end

      // take a request and read slot zero
      S_IDLE: begin
        if (req_acc) begin
          op_d    = req.op;
          key_d   = req.name_key;
          owner_d = req.owner_id;
          n_d     = act_n;
          hit_d   = 1'b0;
          free_d  = 1'b0;
          if (act_n == '0) begin
            state_d = S_FINISH;
          end else begin
            rd_en     = 1'b1;
            chk_vld_d = 1'b1;
            chk_idx_d = '0;
            issue_d   = CntW'(1);
            state_d   = S_SCAN;
          end
        end
      end

      // one slot read and one slot checked per cycle
      S_SCAN: begin
        if (issue_q < n_q) begin
          rd_en     = 1'b1;
          rd_addr   = issue_q[IdxW-1:0];
          chk_vld_d = 1'b1;
          chk_idx_d = issue_q[IdxW-1:0];
          issue_d   = issue_q + CntW'(1);
        end
        if (chk_vld_q) begin
          if (last_chk) begin
            state_d = S_FINISH;
          end
          case (op_q)
            OP_REGISTER: begin
              if (key_hit) begin
                hit_d   = 1'b1;
                state_d = S_FINISH;
              end else if (!rd_data_q.vld && !free_q) begin
                free_d     = 1'b1;
                free_idx_d = chk_idx_q;
              end
            end
            OP_UNREGISTER: begin
              if (key_hit) begin
                wr_en   = 1'b1;
                state_d = S_FINISH;
              end
            end
            OP_LOOKUP: begin
              if (key_hit) begin
                hit_d     = 1'b1;
                hit_idx_d = chk_idx_q;
                state_d   = S_FINISH;
              end
            end
            OP_RELEASE: begin
              if (own_hit) begin
                wr_en = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end

      // claim the free slot on register; register and lookup post the answer
      S_FINISH: begin
        if (op_q == OP_UNREGISTER || op_q == OP_RELEASE) begin
          state_d = S_IDLE;
        end else if (out_free) begin
          state_d    = S_IDLE;
          out_vld_d  = 1'b1;
          out_port_d = '0;
          if (op_q == OP_LOOKUP) begin
            if (hit_q) begin
              out_st_d   = ST_OK;
              out_port_d = first_port_q + PortW'(hit_idx_q);
            end else begin
              out_st_d = ST_UNKNOWN;
            end
          end else if (hit_q) begin
            out_st_d = ST_EXISTS;
          end else if (free_q) begin
            wr_en         = 1'b1;
            wr_addr       = free_idx_q;
            wr_data.vld   = 1'b1;
            wr_data.owner = owner_q;
            wr_data.key   = key_q;
            out_st_d      = ST_OK;
            out_port_d    = first_port_q + PortW'(free_idx_q);
          end else begin
            out_st_d = ST_NO_FREE;
          end
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      clr_q     <= '0;
      chk_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
      issue_q   <= '0;
      n_q       <= '0;
      hit_q     <= 1'b0;
      free_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      chk_vld_q <= chk_vld_d;
      out_vld_q <= out_vld_d;
      issue_q   <= issue_d;
      n_q       <= n_d;
      hit_q     <= hit_d;
      free_q    <= free_d;
    end
  end

  // request and answer payload
  always_ff @(posedge clk_i) begin
    chk_idx_q  <= chk_idx_d;
    op_q       <= op_d;
    key_q      <= key_d;
    owner_q    <= owner_d;
    hit_idx_q  <= hit_idx_d;
    free_idx_q <= free_idx_d;
    out_st_q   <= out_st_d;
    out_port_q <= out_port_d;
  end

endmodule
